@@ rtl/core/input_capture_period_frequency_defines.svh @@
// Assertion macros for the input capture period and frequency meter.
// Used by modules that have clk and rst in scope; no other dependencies.
`ifndef INPUT_CAPTURE_PERIOD_FREQUENCY_DEFINES_SVH
`define INPUT_CAPTURE_PERIOD_FREQUENCY_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk edge outside of reset.
`define ICPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising clk edge, reset included.
`define ICPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICPF_ASSERT(label, prop, msg)
`define ICPF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/core/icpf_pkg.sv @@
// Shared types and constants for the input capture period and frequency meter.
// No dependencies.
`timescale 1ns / 1ps

package icpf_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int CAPTURE_W         = 16;
  localparam int DIV_W             = 32;
  localparam int CFG_INDEX_W       = 8;
  localparam int CFG_DATA_W        = 32;
  localparam int BUS_CLOCK_W       = 31;

  localparam logic [BUS_CLOCK_W-1:0] BUS_CLOCK_RESET = 31'd16000000;

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_BUS_CLOCK_HZ = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUS_DIVIDED  = 8'd1;

  // Control from the sequencer to the shared divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the shared divider back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/input_capture_period_frequency.sv @@
// Input capture period and frequency meter, top level with sequencer.
// Depends on icpf_pkg, icpf_divider and input_capture_period_frequency_defines.svh.
// Usage: s_* takes one word per timer event (tuser [0] overflow, [1] capture,
//   tdata the captured counter value); m_* returns one word per input word
//   (tdata period_ticks low half, frequency_hz high half; tuser measurement_ready).
//   cfg writes bus_clock_hz (index 0) and bus_divided (index 1) and drops
//   other indexes; cfg_ready is always high, write only while idle.
// Flow: a word that divides passes through the CALC state, which updates
//   the period state, the 32 steps of the shared restoring divider (one
//   quotient bit each), the DIV state, which sees it finish, and the DONE
//   state, which loads the output. Before the first capture or on a zero
//   period the divide is skipped and CALC goes straight to DONE.
//   s_tready is high only while the sequencer is idle, so one word is in work
//   at a time: a new word is taken only after the last result has loaded.
//   The next word may be taken while a finished result still waits.
// Reset: rst clears the measurement state, loads the register defaults
//   (16 MHz, undivided) and empties the output register.
// Stall: while m_tready is low the result holds in the output register and
//   the next result waits in the sequencer until it drains.
`timescale 1ns / 1ps

`include "input_capture_period_frequency_defines.svh"

module input_capture_period_frequency
  import icpf_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Event words
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // [15:0] capture_value
  input  logic [1:0]             s_tuser,   // [0] overflow_event, [1] capture_event
  // Result words
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [63:0]            m_tdata,   // [31:0] period_ticks, [63:32] frequency_hz
  output logic                   m_tuser,   // [0] measurement_ready
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Captures wider than the counter window keep only the window bits
  localparam logic [CAPTURE_W-1:0] CapMask = (COUNTER_WIDTH >= CAPTURE_W) ? '1 :
      CAPTURE_W'((64'd1 << COUNTER_WIDTH) - 64'd1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [BUS_CLOCK_W-1:0] bus_clock_hz;
  logic                   bus_divided;

  // Measurement state
  logic [CAPTURE_W-1:0] previous_capture;
  logic [DIV_W-1:0]     overflow_tally;
  logic [DIV_W-1:0]     period_store;
  logic                 ready_flag;

  // Accepted word
  logic                 ev_overflow;
  logic                 ev_capture;
  logic [CAPTURE_W-1:0] ev_value;

  logic                 use_div;

  logic [DIV_W-1:0] tally_next;
  logic [DIV_W-1:0] period_next;
  logic             ready_next;
  logic [DIV_W-1:0] timer_clock;
  logic             out_free;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] quotient;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz <= BUS_CLOCK_RESET;
      bus_divided  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUS_CLOCK_HZ: bus_clock_hz <= cfg_data[BUS_CLOCK_W-1:0];
        REG_BUS_DIVIDED:  bus_divided  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Timer clock doubles when the bus prescaler divides; 31 bits times two fit
  assign timer_clock = bus_divided ? {bus_clock_hz, 1'b0} : {1'b0, bus_clock_hz};

  // Count the overflow first, then close the period on a capture. The window
  // correction for a capture below the previous one folds into a plain
  // 32-bit difference of the two captures.
  always_comb begin
    tally_next  = overflow_tally + DIV_W'(ev_overflow);
    period_next = period_store;
    ready_next  = ready_flag;
    if (ev_capture) begin
      period_next = DIV_W'(64'(tally_next) << COUNTER_WIDTH)
                  + DIV_W'(ev_value) - DIV_W'(previous_capture);
      ready_next  = 1'b1;
    end
  end

  assign div_ctrl.start = (state == ST_CALC) && ready_next && (period_next != '0);

  icpf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (timer_clock),
    .divisor  (period_next),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      previous_capture <= '0;
      overflow_tally   <= '0;
      period_store     <= '0;
      ready_flag       <= 1'b0;
      m_tvalid         <= 1'b0;
      use_div          <= 1'b0;
    end else begin
      // Drop the word once taken, unless a new one loads in the same cycle
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          // Commit the new state and start the divide if one is needed
          period_store <= period_next;
          ready_flag   <= ready_next;
          use_div      <= div_ctrl.start;
          if (ev_capture) begin
            previous_capture <= ev_value;
            overflow_tally   <= '0;
          end else begin
            overflow_tally <= tally_next;
          end
          state <= div_ctrl.start ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register drains
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the accepted word and load the result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ev_overflow <= s_tuser[0];
      ev_capture  <= s_tuser[1];
      ev_value    <= s_tdata & CapMask;
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {(use_div ? quotient : DIV_W'(0)), period_store};
      m_tuser <= ready_flag;
    end
  end

  `ICPF_ASSERT(a_idle_div_quiet, s_tready |-> !div_stat.busy,
               "divider busy while accepting a new word")
  `ICPF_ASSERT(a_done_in_div, div_stat.done |-> (state == ST_DIV),
               "divider finished outside the divide state")
  `ICPF_ASSERT(a_load_from_done, $rose(m_tvalid) |-> $past(state == ST_DONE),
               "result loaded without a finished computation")
  `ICPF_ASSERT(a_ready_sticky, ready_flag |=> ready_flag,
               "measurement ready flag dropped")

endmodule

@@ rtl/core/icpf_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on icpf_pkg.
`timescale 1ns / 1ps

module icpf_divider
  import icpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  localparam int CountW = $clog2(DIV_W);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [CountW-1:0] count;
  logic              busy;
  logic              done;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;

  // One shared subtractor: shift in the next dividend bit and try the divisor
  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= CountW'(DIV_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

@@ bench/icpf_period_checker.sv @@
// Checker for the input capture period and frequency meter: predicts each result word.
// Watches the event, result and cfg channels; depends on icpf_pkg only.
`timescale 1ns / 1ps

module icpf_period_checker
  import icpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [15:0]            s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [63:0]            m_tdata,
  input  logic                   m_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     results_seen
);

  typedef struct packed {
    logic [31:0] period_ticks;
    logic [31:0] frequency_hz;
    logic        measurement_ready;
  } meter_result_t;

  localparam logic [63:0] WINDOW = 64'h1_0000;

  logic [BUS_CLOCK_W-1:0] bus_clock_hz;
  logic                   bus_divided;
  logic [CAPTURE_W-1:0]   last_capture;
  logic [31:0]            wrap_count;
  logic [31:0]            period_hold;
  logic                   ready_hold;
  meter_result_t          expected_meter[$];

  // Advance the meter state by one event word and return the word it reports.
  function automatic meter_result_t measure(logic ovf, logic cap, logic [15:0] value);
    logic [63:0]   span;
    logic [31:0]   timer_hz;
    meter_result_t r;
    if (ovf) begin
      wrap_count = wrap_count + 32'd1;
    end
    if (cap) begin
      span = {32'd0, wrap_count} * WINDOW + {48'd0, value - last_capture};
      // a capture below the previous one gives back one window
      if (value < last_capture) begin
        span = span - WINDOW;
      end
      period_hold  = span[31:0];
      last_capture = value;
      wrap_count   = 32'd0;
      ready_hold   = 1'b1;
    end
    timer_hz = bus_divided ? {bus_clock_hz, 1'b0} : {1'b0, bus_clock_hz};
    r.period_ticks      = period_hold;
    r.frequency_hz      = (ready_hold && period_hold != 32'd0) ? timer_hz / period_hold : 32'd0;
    r.measurement_ready = ready_hold;
    return r;
  endfunction

  always @(posedge clk) begin
    meter_result_t want;
    if (rst) begin
      bus_clock_hz = BUS_CLOCK_RESET;
      bus_divided  = 1'b0;
      last_capture = '0;
      wrap_count   = '0;
      period_hold  = '0;
      ready_hold   = 1'b0;
      expected_meter.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BUS_CLOCK_HZ) begin
          bus_clock_hz = cfg_data[BUS_CLOCK_W-1:0];
        end else if (cfg_index == REG_BUS_DIVIDED) begin
          bus_divided = cfg_data[0];
        end
      end
      // compare before pushing so a stray word never meets its own prediction
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_meter.size() == 0) begin
          $error("result word with no prediction waiting: tdata %h tuser %b", m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = expected_meter.pop_front();
          if (m_tdata[31:0] !== want.period_ticks) begin
            $error("period_ticks: expected %0d, got %0d", want.period_ticks, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tdata[63:32] !== want.frequency_hz) begin
            $error("frequency_hz: expected %0d, got %0d", want.frequency_hz, m_tdata[63:32]);
            mismatches++;
          end
          if (m_tuser !== want.measurement_ready) begin
            $error("measurement_ready: expected %0d, got %0d", want.measurement_ready, m_tuser);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_meter.push_back(measure(s_tuser[0], s_tuser[1], s_tdata));
      end
    end
    pending = expected_meter.size();
  end

endmodule

@@ bench/input_capture_period_frequency_tb.sv @@
// Testbench top for the input capture period and frequency meter: stimulus and verdict.
// Depends on icpf_pkg, input_capture_period_frequency and icpf_period_checker.
`timescale 1ns / 1ps

module input_capture_period_frequency_tb;
  import icpf_pkg::*;

  // Indexes with no register behind them; writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = 8'hFF;

  localparam int DIRECTED_WORDS = 22;
  localparam int PHASE_WORDS    = 155;
  localparam int PHASES         = 6;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [15:0]            s_tdata;   // [15:0] capture_value
  logic [1:0]             s_tuser;   // [0] overflow_event, [1] capture_event
  logic                   m_tvalid;
  logic                   m_tready;
  logic [63:0]            m_tdata;   // [31:0] period_ticks, [63:32] frequency_hz
  logic                   m_tuser;   // [0] measurement_ready
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int pending;
  int results_seen;

  // Idle switches per phase: off gives back-to-back stretches
  bit tx_idle;
  bit rx_idle;

  int          words_sent;
  int          captures_sent;
  int          clock_settings;
  logic [15:0] last_value;

  input_capture_period_frequency u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  icpf_period_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one event word. Called and returns at a falling edge; tvalid is left
  // high so a following word with no gap keeps it up without a second update.
  task automatic send_event(logic ovf, logic cap, logic [15:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {cap, ovf};
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    words_sent++;
    if (cap) begin
      captures_sent++;
      last_value = value;
    end
  endtask

  // Mix of captures, overflow marks and plain words; some captures land at or just
  // above the previous one so short periods give large frequencies.
  task automatic send_random_event();
    int          pick;
    logic [15:0] value;
    pick  = $urandom_range(0, 99);
    value = 16'($urandom);
    if (pick < 35) begin
      send_event(1'b0, 1'b1, value);
    end else if (pick < 55) begin
      send_event(1'b1, 1'b0, value);
    end else if (pick < 70) begin
      send_event(1'b1, 1'b1, value);
    end else if (pick < 80) begin
      send_event(1'b0, 1'b0, value);
    end else if (pick < 95) begin
      send_event(pick[0], 1'b1, last_value + 16'($urandom_range(0, 3)));
    end else begin
      // a run of wraps, then a capture
      repeat ($urandom_range(2, 12)) send_event(1'b1, 1'b0, 16'($urandom));
      send_event(1'b0, 1'b1, value);
    end
  endtask

  // Hold cfg_valid through back-to-back writes; the caller drops it.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write both registers with junk in the bits above each register's width.
  task automatic set_clock(logic [BUS_CLOCK_W-1:0] clock_hz, logic divided);
    write_reg(REG_BUS_CLOCK_HZ, {1'($urandom), clock_hz});
    write_reg(REG_BUS_DIVIDED, {31'($urandom), divided});
    cfg_valid <= 1'b0;
    clock_settings++;
  endtask

  // Drain every prediction, then let the divider pipe run out before touching cfg.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Result side: per word, optionally stall once the word is on offer.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        do @(posedge clk); while (!m_tvalid);
        repeat (stall - 1) @(posedge clk);
        @(negedge clk);
        m_tready <= 1'b1;
      end
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    words_sent     = 0;
    captures_sent  = 0;
    clock_settings = 1;
    last_value     = '0;
    rst            = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset clock settings
    send_event(1'b0, 1'b0, 16'h0000);  // not ready yet: period and frequency read 0
    send_event(1'b0, 1'b0, 16'hFFFF);  // value without a capture mark is ignored
    send_event(1'b1, 1'b0, 16'h0000);
    send_event(1'b1, 1'b0, 16'h0000);
    send_event(1'b0, 1'b1, 16'h0000);  // first capture: two whole windows
    send_event(1'b0, 1'b1, 16'h0000);  // same value again: zero period, no divide
    send_event(1'b0, 1'b1, 16'hFFFF);  // widest step inside one window
    send_event(1'b0, 1'b1, 16'h0001);  // below previous with no wrap: period underflows
    send_event(1'b1, 1'b1, 16'h8000);  // wrap counted before the capture
    send_event(1'b1, 1'b1, 16'h0000);  // both marks and below previous
    send_event(1'b0, 1'b1, 16'hAAAA);
    send_event(1'b0, 1'b1, 16'h5555);
    send_event(1'b0, 1'b1, 16'h5556);  // one tick: frequency equals timer clock
    repeat (8) send_event(1'b1, 1'b0, 16'($urandom));
    send_event(1'b0, 1'b1, 16'h5556);  // whole windows only

    for (int phase = 1; phase <= PHASES; phase++) begin
      settle();
      tx_idle = (phase % 3 != 1);
      rx_idle = (phase % 3 != 1) ? (phase % 2 == 0) || (phase == 5) : 1'b0;
      case (phase)
        1: begin
          write_reg(REG_BUS_CLOCK_HZ, 32'hFFFF_FFFF);
          set_clock(31'h7FFF_FFFF, 1'b1);  // largest timer clock
        end
        2: set_clock(31'd0, 1'b0);
        3: set_clock(31'd1, 1'b1);
        4: begin
          write_reg(REG_SPARE, $urandom);
          write_reg(REG_TOP, $urandom);
          set_clock(31'($urandom), 1'b0);
        end
        5: set_clock(31'($urandom_range(0, 100000)), 1'b1);
        default: set_clock(31'($urandom), 1'($urandom_range(0, 1)));
      endcase
      while (words_sent < DIRECTED_WORDS + phase * PHASE_WORDS) send_random_event();
    end

    settle();
    $display("Sent %0d event words (%0d with a capture) over %0d clock settings;",
             words_sent, captures_sent, clock_settings);
    $display("checked %0d result words, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a clean run needs well under a tenth of this
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
